### rtl/dws_pkg.sv
`timescale 1ns / 1ps
package dws_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = 32 + $clog2(DEPTH);
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);
	localparam int UPC_W = 4;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_STATS      = 3'd4
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_LATCH    = 3'd1,
		OP_PUSH     = 3'd2,
		OP_POP      = 3'd3,
		OP_WALK_CLR = 3'd4,
		OP_WALK_ACC = 3'd5,
		OP_DIV_LOAD = 3'd6
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_IDLE_WAIT = 3'd2,
		C_DISPATCH  = 3'd3,
		C_WALK_MORE = 3'd4,
		C_DIV_BUSY  = 3'd5
	} cond_t;

	typedef struct packed {
		cond_t              cond;
		logic [UPC_W-1:0]   target;
		dp_op_t             op;
		logic               emit;
		status_t            status;
		logic               stats;
	} ctrl_word_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic       walk_more;
		logic       div_busy;
		logic [2:0] command;
	} flags_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
		logic signed [35:0] total;
		logic signed [31:0] average;
	} out_item_t;

	localparam logic [UPC_W-1:0] A_IDLE      = 4'd0;
	localparam logic [UPC_W-1:0] A_DISPATCH  = 4'd1;
	localparam logic [UPC_W-1:0] A_PUSH      = 4'd2;
	localparam logic [UPC_W-1:0] A_POP       = 4'd3;
	localparam logic [UPC_W-1:0] A_STAT_CLR  = 4'd4;
	localparam logic [UPC_W-1:0] A_READ      = 4'd5;
	localparam logic [UPC_W-1:0] A_ACC       = 4'd6;
	localparam logic [UPC_W-1:0] A_DIV_LOAD  = 4'd7;
	localparam logic [UPC_W-1:0] A_DIV_WAIT  = 4'd8;
	localparam logic [UPC_W-1:0] A_STAT_DONE = 4'd9;
	localparam logic [UPC_W-1:0] A_FULL      = 4'd10;
	localparam logic [UPC_W-1:0] A_EMPTY     = 4'd11;
	localparam logic [UPC_W-1:0] A_NOP       = 4'd12;

	function automatic ctrl_word_t mk(input cond_t c, input logic [UPC_W-1:0] t,
			input dp_op_t o, input logic e, input status_t s, input logic st);
		ctrl_word_t w;
		w.cond   = c;
		w.target = t;
		w.op     = o;
		w.emit   = e;
		w.status = s;
		w.stats  = st;
		return w;
	endfunction

	// microprogram: one control word per step
	function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
		ctrl_word_t w;
		case (addr)
			A_IDLE:      w = mk(C_IDLE_WAIT, A_IDLE, OP_LATCH, 1'b0, ST_OK, 1'b0);
			A_DISPATCH:  w = mk(C_DISPATCH, A_IDLE, OP_NONE, 1'b0, ST_OK, 1'b0);
			A_PUSH:      w = mk(C_ALWAYS, A_IDLE, OP_PUSH, 1'b1, ST_OK, 1'b0);
			A_POP:       w = mk(C_ALWAYS, A_IDLE, OP_POP, 1'b1, ST_OK, 1'b0);
			A_STAT_CLR:  w = mk(C_NEXT, A_IDLE, OP_WALK_CLR, 1'b0, ST_OK, 1'b0);
			A_READ:      w = mk(C_NEXT, A_IDLE, OP_NONE, 1'b0, ST_OK, 1'b0);
			A_ACC:       w = mk(C_WALK_MORE, A_READ, OP_WALK_ACC, 1'b0, ST_OK, 1'b0);
			A_DIV_LOAD:  w = mk(C_NEXT, A_IDLE, OP_DIV_LOAD, 1'b0, ST_OK, 1'b0);
			A_DIV_WAIT:  w = mk(C_DIV_BUSY, A_DIV_WAIT, OP_NONE, 1'b0, ST_OK, 1'b0);
			A_STAT_DONE: w = mk(C_ALWAYS, A_IDLE, OP_NONE, 1'b1, ST_OK, 1'b1);
			A_FULL:      w = mk(C_ALWAYS, A_IDLE, OP_NONE, 1'b1, ST_FULL, 1'b0);
			A_EMPTY:     w = mk(C_ALWAYS, A_IDLE, OP_NONE, 1'b1, ST_EMPTY, 1'b0);
			A_NOP:       w = mk(C_ALWAYS, A_IDLE, OP_NONE, 1'b1, ST_OK, 1'b0);
			default:     w = mk(C_ALWAYS, A_IDLE, OP_NONE, 1'b0, ST_OK, 1'b0);
		endcase
		return w;
	endfunction

endpackage

### rtl/dws_sequencer.sv
`timescale 1ns / 1ps
module dws_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dws_pkg::flags_t   flags,
	output dws_pkg::ctrl_word_t ctrl,
	output logic              busy
);
	import dws_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_d;
	logic [UPC_W-1:0] dispatch;

	assign ctrl = ucode(upc_q);
	assign busy = (upc_q != A_IDLE);

	always_comb begin
		if (flags.command inside {CMD_PUSH_FRONT, CMD_PUSH_BACK}) begin
			dispatch = flags.full ? A_FULL : A_PUSH;
		end else if (flags.command inside {CMD_POP_FRONT, CMD_POP_BACK}) begin
			dispatch = flags.empty ? A_EMPTY : A_POP;
		end else if (flags.command == CMD_STATS) begin
			dispatch = flags.empty ? A_EMPTY : A_STAT_CLR;
		end else begin
			dispatch = A_NOP;
		end
	end

	always_comb begin
		upc_d = UPC_W'(upc_q + 1'b1);
		case (ctrl.cond)
			C_NEXT: ;
			C_ALWAYS: upc_d = ctrl.target;
			C_IDLE_WAIT: begin
				if (!start) upc_d = ctrl.target;
			end
			C_DISPATCH: upc_d = dispatch;
			C_WALK_MORE: begin
				if (flags.walk_more) upc_d = ctrl.target;
			end
			C_DIV_BUSY: begin
				if (flags.div_busy) upc_d = ctrl.target;
			end
			default: upc_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

### rtl/dws_divider.sv
`timescale 1ns / 1ps
module dws_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic signed [dws_pkg::SUM_W-1:0]   dividend,
	input  logic [dws_pkg::CNT_W-1:0]          divisor,
	output logic                               busy,
	output logic signed [31:0]                 quotient
);
	import dws_pkg::*;

	logic [DIV_CNT_W-1:0] iter_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [SUM_W-1:0]     quot_q;
	logic                 neg_q;
	logic [SUM_W-1:0]     mag;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       diff;
	logic                 ge;
	logic [31:0]          qlow;

	// restoring division on the magnitude, one quotient bit per cycle
	assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign busy  = (iter_q != '0);
	assign qlow  = quot_q[31:0];
	assign quotient = neg_q ? (~qlow + 32'd1) : qlow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (load) begin
			iter_q <= DIV_CNT_W'(SUM_W);
		end else if (busy) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q  <= dividend[SUM_W-1];
			quot_q <= mag;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy) begin
			rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quot_q <= {quot_q[SUM_W-2:0], ge};
		end
	end

endmodule

### rtl/dws_datapath.sv
`timescale 1ns / 1ps
module dws_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dws_pkg::in_item_t                  request,
	input  dws_pkg::ctrl_word_t                ctrl,
	input  logic                               div_busy,
	input  logic signed [31:0]                 div_quot,
	output dws_pkg::flags_t                    flags,
	output logic signed [dws_pkg::SUM_W-1:0]   sum,
	output logic [dws_pkg::CNT_W-1:0]          count,
	output logic                               done,
	output dws_pkg::out_item_t                 result
);
	import dws_pkg::*;

	logic [31:0]              mem [DEPTH];
	logic [31:0]              rdata_q;
	logic [2:0]               cmd_q;
	logic signed [31:0]       value_q;
	logic [IDX_W-1:0]         front_q;
	logic [IDX_W-1:0]         front_d;
	logic [IDX_W-1:0]         front_dec;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic [CNT_W-1:0]         ptr_q;
	logic signed [31:0]       lo_q;
	logic signed [31:0]       hi_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [31:0]       x;
	logic [IDX_W-1:0]         wr_addr;
	logic [IDX_W-1:0]         rd_addr;
	logic                     done_q;
	out_item_t                result_q;

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign wr_addr   = (cmd_q == CMD_PUSH_FRONT) ? front_dec : wrap(front_q, count_q);
	assign rd_addr   = wrap(front_q, ptr_q);
	assign x         = rdata_q;

	assign flags.full      = (count_q == CNT_W'(DEPTH));
	assign flags.empty     = (count_q == '0);
	assign flags.walk_more = ((CNT_W+1)'(ptr_q) + 1'b1) != (CNT_W+1)'(count_q);
	assign flags.div_busy  = div_busy;
	assign flags.command   = cmd_q;

	assign sum    = sum_q;
	assign count  = count_q;
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_LATCH) begin
			cmd_q   <= request.command;
			value_q <= request.value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_PUSH) begin
			mem[wr_addr] <= value_q;
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		case (ctrl.op)
			OP_PUSH: begin
				count_d = count_q + 1'b1;
				if (cmd_q == CMD_PUSH_FRONT) front_d = front_dec;
			end
			OP_POP: begin
				count_d = count_q - 1'b1;
				if (cmd_q == CMD_POP_FRONT) front_d = wrap(front_q, CNT_W'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (ctrl.op == OP_WALK_CLR) begin
				ptr_q <= '0;
			end else if (ctrl.op == OP_WALK_ACC) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// fold one entry per pass; the first entry seeds min and max
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_WALK_CLR) begin
			sum_q <= '0;
		end else if (ctrl.op == OP_WALK_ACC) begin
			sum_q <= sum_q + SUM_W'(x);
			if (ptr_q == '0) begin
				lo_q <= x;
				hi_q <= x;
			end else begin
				if (x < lo_q) lo_q <= x;
				if (x > hi_q) hi_q <= x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_q.status <= ctrl.status;
			result_q.count  <= 5'(count_d);
			if (ctrl.stats) begin
				result_q.smallest <= lo_q;
				result_q.largest  <= hi_q;
				result_q.total    <= 36'(sum_q);
				result_q.average  <= div_quot;
			end else begin
				result_q.smallest <= '0;
				result_q.largest  <= '0;
				result_q.total    <= '0;
				result_q.average  <= '0;
			end
		end
	end

endmodule

### rtl/deque_with_statistics_top.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words with statistics.
// Command channel: drive request (command, value) and raise start; the
// command is taken at the rising edge where start is high and busy is low.
// busy stays high from that edge until the result beat has been produced.
// Result channel: done is high for exactly one cycle with the result on the
// result port; the receiver cannot hold it off, so capture it that cycle.
// From accept to done, push, pop, unknown commands and any command refused as
// full or empty pass the dispatch step and then their action step, whose beat
// is registered onto done. Statistics walk the held entries from front to
// back, a store read step and then a fold step per entry, then run a serial
// divider giving one quotient bit per cycle over the 36-bit sum. The next
// command may be accepted in the cycle done is high. One command is in flight
// at a time; the microprogram step counter and the single store read port set the pace.
// Reset clears front index, entry count and the sequencer; stored words are
// not cleared and are only read once pushed.
module deque_with_statistics_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  dws_pkg::in_item_t    request,
	output logic                 done,
	output dws_pkg::out_item_t   result
);
	import dws_pkg::*;

	ctrl_word_t               ctrl;
	flags_t                   flags;
	logic                     div_busy;
	logic signed [31:0]       div_quot;
	logic signed [SUM_W-1:0]  sum;
	logic [CNT_W-1:0]         count;

	dws_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	dws_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.ctrl     (ctrl),
		.div_busy (div_busy),
		.div_quot (div_quot),
		.flags    (flags),
		.sum      (sum),
		.count    (count),
		.done     (done),
		.result   (result)
	);

	dws_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ctrl.op == OP_DIV_LOAD),
		.dividend (sum),
		.divisor  (count),
		.busy     (div_busy),
		.quotient (div_quot)
	);

endmodule

### tb/sv/deque_with_statistics_top_test.sv
`timescale 1ns / 1ps
module deque_with_statistics_top_test;
	import dws_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_item_t  request = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	deque_with_statistics_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #4 clk = ~clk;

	// shadow of the deque contents
	logic signed [31:0] shadow_words [DEPTH];
	int shadow_front = 0;
	int shadow_count = 0;

	in_item_t  command_backlog [$];
	out_item_t awaited_results [$];

	int commands_total = 0;
	int accepted = 0;
	int failures = 0;
	int idle_left = 0;
	bit calm = 1'b0;
	int n_push = 0, n_pop = 0, n_stats = 0, n_full = 0, n_empty = 0, n_ignored = 0;
	int deepest = 0;

	function automatic out_item_t apply_deque_command(in_item_t it);
		out_item_t r;
		longint acc, lo, hi, w;
		r = '0;
		acc = 0;
		case (it.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					if (it.command == CMD_PUSH_FRONT) begin
						shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
						shadow_words[shadow_front] = it.value;
					end else begin
						shadow_words[(shadow_front + shadow_count) % DEPTH] = it.value;
					end
					shadow_count++;
					n_push++;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					if (it.command == CMD_POP_FRONT)
						shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
					n_pop++;
				end
			end
			CMD_STATS: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					lo = longint'(shadow_words[shadow_front]);
					hi = lo;
					for (int i = 0; i < shadow_count; i++) begin
						w = longint'(shadow_words[(shadow_front + i) % DEPTH]);
						if (w < lo)
							lo = w;
						if (w > hi)
							hi = w;
						acc += w;
					end
					r.smallest = 32'(lo);
					r.largest  = 32'(hi);
					r.total    = 36'(acc);
					r.average  = 32'(acc / longint'(shadow_count));
					n_stats++;
				end
			end
			default: n_ignored++;
		endcase
		r.count = 5'(shadow_count);
		if (shadow_count > deepest)
			deepest = shadow_count;
		return r;
	endfunction

	function automatic bit field_ok(string name, logic [35:0] want, logic [35:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void add_item(logic [2:0] cmd, logic signed [31:0] val);
		in_item_t it;
		it.command = cmd;
		it.value = val;
		command_backlog.push_back(it);
		commands_total++;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			4: return 32'($urandom_range(0, 20)) - 32'sd10;
			default: return $urandom();
		endcase
	endfunction

	// beat sender: hold start until accepted, then idle for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited_results.push_back(apply_deque_command(request));
				accepted++;
				if ($urandom_range(0, 39) == 0)
					calm = !calm;
				idle_left = calm ? 0 : $urandom_range(0, 18);
				if (idle_left == 0 && command_backlog.size() > 0)
					request <= command_backlog.pop_front();
				else
					start <= 1'b0;
			end else if (!start) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (command_backlog.size() > 0) begin
					request <= command_backlog.pop_front();
					start <= 1'b1;
				end
			end
		end
	end

	// result beats: compare against the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		bit ok;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result beat, actual %0h", $time, result);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				ok = field_ok("status", want.status, result.status)
					& field_ok("count", want.count, result.count)
					& field_ok("smallest", want.smallest, result.smallest)
					& field_ok("largest", want.largest, result.largest)
					& field_ok("total", want.total, result.total)
					& field_ok("average", want.average, result.average);
				if (!ok)
					failures++;
			end
		end
	end

	initial begin
		int r, burst_left, push_share;
		logic [2:0] cmd;

		// empty store, ignored commands, then fill to full with the most negative word
		add_item(CMD_STATS, 32'sh12345678);
		add_item(CMD_POP_FRONT, -32'sd1);
		add_item(CMD_POP_BACK, 32'sh7fffffff);
		add_item(3'd5, 32'sh80000000);
		add_item(3'd7, 32'sh55aa55aa);
		add_item(CMD_PUSH_FRONT, 32'sh7fffffff);
		add_item(CMD_STATS, '0);
		add_item(CMD_POP_BACK, '0);
		for (int i = 0; i < DEPTH; i++)
			add_item(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, 32'sh80000000);
		add_item(CMD_PUSH_BACK, 32'sh7fffffff);
		add_item(CMD_STATS, '0);
		add_item(CMD_POP_FRONT, '0);

		// bursts that lean toward filling, draining or neither
		burst_left = 0;
		push_share = 35;
		for (int n = 0; n < 1180; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(15, 45);
				case ($urandom_range(0, 2))
					0: push_share = 55;
					1: push_share = 15;
					default: push_share = 35;
				endcase
			end
			burst_left--;
			r = $urandom_range(0, 99);
			if (r < 3)
				cmd = 3'($urandom_range(5, 7));
			else if (r < 18)
				cmd = CMD_STATS;
			else if (r < 18 + push_share)
				cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			else
				cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
			add_item(cmd, pick_value());
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < commands_total)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		$display("Ran %0d commands: %0d pushes, %0d pops, %0d statistics, %0d ignored",
			accepted, n_push, n_pop, n_stats, n_ignored);
		$display("Refused %0d pushes as full and %0d commands as empty; deepest fill %0d",
			n_full, n_empty, deepest);
		if (failures == 0)
			$display("** deque_with_statistics_top: PASSED **");
		else
			$display("** deque_with_statistics_top: FAILED **");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout with %0d of %0d commands accepted", accepted, commands_total);
		$display("** deque_with_statistics_top: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/dws_pkg.sv
rtl/dws_sequencer.sv
rtl/dws_divider.sv
rtl/dws_datapath.sv
rtl/deque_with_statistics_top.sv
tb/sv/deque_with_statistics_top_test.sv
